// ----- hw/rtl/rfe_pkg.sv -----
// ----------------------------------------------------------------------------
// rfe_pkg: shared types and constants of the PWM register file emulator
// Holds the action codes, register file geometry, the pulse width arithmetic
// constants and the structs that travel between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rfe_pkg;

  localparam int REG_BYTES = 16;
  localparam int IDX_W     = $clog2(REG_BYTES);

  localparam logic [7:0]       PRESCALE_PTR = 8'hFE;
  localparam logic [IDX_W-1:0] PRESCALE_IDX = 4'h5;
  localparam logic [7:0]       OFF_BASE     = 8'h08;
  localparam logic [7:0]       READ_OOR     = 8'hFF;
  localparam logic [15:0]      PULSE_BAD_CH = 16'hFFFF;

  // Division by 25 is a multiplication by floor(2^24 / 25) and one correction.
  localparam int DIVISOR     = 25;
  localparam int PROD_W      = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 20;
  localparam int QUOT_W      = 21;
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);

  typedef enum logic [2:0] {
    ACT_SET_PTR = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_READ    = 3'd2,
    ACT_QUERY   = 3'd3,
    ACT_POLL    = 3'd4
  } action_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic [15:0] pulse_us;
    logic        overflow;
  } pulse_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rfe_regmem.sv -----
// ----------------------------------------------------------------------------
// rfe_regmem: register file storage
// A 16 x 8 synchronous memory with one write port and one read port whose
// data is registered. Valid bits cleared by reset make unwritten bytes read
// as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_regmem (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  rfe_pkg::mem_wr_t             wr_i,
  input  wire                          rd_en_i,
  input  wire  [rfe_pkg::IDX_W-1:0]    rd_addr_i,
  output logic [7:0]                   rd_data_o
);

  logic [7:0]                  mem [rfe_pkg::REG_BYTES];
  logic [rfe_pkg::REG_BYTES-1:0] valid_q;
  logic [7:0]                  rdata_q;
  logic                        rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : 8'd0;

endmodule

`default_nettype wire

// ----- hw/rtl/rfe_pulse.sv -----
// ----------------------------------------------------------------------------
// rfe_pulse: pulse width arithmetic
// Three-stage pipeline computing off * (prescale + 1) / 25: the product, a
// reciprocal multiplication, and a single remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_pulse (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire  [15:0]          off_i,
  input  wire  [7:0]           prescale_i,
  output logic                 done_o,
  output rfe_pkg::pulse_res_t  res_o
);

  localparam int PW = rfe_pkg::PROD_W;
  localparam int RW = rfe_pkg::RECIP_W;
  localparam int QW = rfe_pkg::QUOT_W;

  logic [2:0]      vld_q;
  logic [8:0]      scale;
  logic [PW-1:0]   prod_d;
  logic [PW-1:0]   prod_q;
  logic [PW-1:0]   prod2_q;
  logic [PW+RW-1:0] recip_prod;
  logic [QW-1:0]   est_q;
  logic [PW-1:0]   est25;
  logic [PW-1:0]   rem;
  logic [QW-1:0]   quot;
  rfe_pkg::pulse_res_t res_q;

  assign scale      = {1'b0, prescale_i} + 9'd1;
  assign prod_d     = {{(PW-16){1'b0}}, off_i} * {{(PW-9){1'b0}}, scale};
  assign recip_prod = {{RW{1'b0}}, prod_q} * {{PW{1'b0}}, rfe_pkg::RECIP_MULT};
  assign est25      = PW'({est_q, 4'b0000}) + PW'({est_q, 3'b000}) + PW'(est_q);
  assign rem        = prod2_q - est25;
  assign quot       = (rem >= PW'(rfe_pkg::DIVISOR)) ? est_q + QW'(1) : est_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q         <= prod_d;
    prod2_q        <= prod_q;
    est_q          <= recip_prod[rfe_pkg::RECIP_SHIFT +: QW];
    res_q.pulse_us <= quot[15:0];
    res_q.overflow <= |quot[QW-1:16];
  end

  assign done_o = vld_q[2];
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pwm_register_file_emulator.sv -----
// ----------------------------------------------------------------------------
// pwm_register_file_emulator: register side of a bus-slave PWM controller
// Keeps a 16-byte register file in a synchronous memory, an 8-bit pointer and
// a write-seen flag, and answers reads, channel pulse width queries and polls.
//
//   Channel  Handshake                Payload
//   in       in_valid_i / in_stall_o  action_i, data_byte_i, channel_i
//   out      out_valid_o / out_stall_i read_data_o, pulse_us_o,
//                                     pulse_overflow_o, write_seen_o
//
// One item is handled at a time. Pointer sets and writes end in idle, polls
// and out-of-range reads go to holding, reads pass a data state; a valid
// channel query needs three memory reads, then the three-stage multiply and divide unit.
// A finished result waits in a holding state while the output register is
// stalled; the output register itself frees the input for the next item.
// Reset clears the memory's valid bits at once, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_register_file_emulator #(
  parameter int CHANNELS = 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  action_i,
  input  wire  [7:0]  data_byte_i,
  input  wire  [7:0]  channel_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [15:0] pulse_us_o,
  output logic        pulse_overflow_o,
  output logic        write_seen_o
);

  localparam int IW = rfe_pkg::IDX_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDATA = 7'b0000010,
    S_QLO   = 7'b0000100,
    S_QHI   = 7'b0001000,
    S_QPS   = 7'b0010000,
    S_ARITH = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  ptr_q, ptr_d;
  logic        flag_q, flag_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]  off_lo_q, off_lo_d;
  logic [7:0]  off_hi_q, off_hi_d;
  logic [7:0]  res_read_q, res_read_d;
  logic [15:0] res_pulse_q, res_pulse_d;
  logic        res_ovf_q, res_ovf_d;
  logic        res_ws_q, res_ws_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_read_q;
  logic [15:0] out_pulse_q;
  logic        out_ovf_q;
  logic        out_ws_q;
  logic        out_load;

  rfe_pkg::mem_wr_t    mem_wr;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic [7:0]          rd_data;
  logic                pulse_start;
  logic                pulse_done;
  rfe_pkg::pulse_res_t pulse_res;

  logic       in_acc;
  logic       ptr_in_range;
  logic [7:0] lo_ofs;

  rfe_regmem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rfe_pulse u_pulse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pulse_start),
    .off_i      ({off_hi_q, off_lo_q}),
    .prescale_i (rd_data),
    .done_o     (pulse_done),
    .res_o      (pulse_res)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && (state_q == S_IDLE);
  assign ptr_in_range = (ptr_q < 8'(rfe_pkg::REG_BYTES));
  assign lo_ofs       = rfe_pkg::OFF_BASE + {channel_i[5:0], 2'b00};
  assign out_load     = (state_q == S_HOLD) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    flag_d      = flag_q;
    idx_d       = idx_q;
    off_lo_d    = off_lo_q;
    off_hi_d    = off_hi_q;
    res_read_d  = res_read_q;
    res_pulse_d = res_pulse_q;
    res_ovf_d   = res_ovf_q;
    res_ws_d    = res_ws_q;
    mem_wr      = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    pulse_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_read_d  = 8'd0;
          res_pulse_d = 16'd0;
          res_ovf_d   = 1'b0;
          res_ws_d    = 1'b0;
          case (action_i)
            rfe_pkg::ACT_SET_PTR: begin
              ptr_d = data_byte_i;
            end
            rfe_pkg::ACT_WRITE: begin
              if (ptr_in_range) begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = ptr_q[IW-1:0];
                mem_wr.data = data_byte_i;
                if (ptr_q[1:0] == 2'b01) begin
                  flag_d = 1'b1;
                end
              end else if (ptr_q == rfe_pkg::PRESCALE_PTR) begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = rfe_pkg::PRESCALE_IDX;
                mem_wr.data = data_byte_i;
                flag_d      = 1'b1;
              end
              ptr_d = ptr_q + 8'd1;
            end
            rfe_pkg::ACT_READ: begin
              if (ptr_in_range) begin
                rd_en   = 1'b1;
                rd_addr = ptr_q[IW-1:0];
                state_d = S_RDATA;
              end else begin
                res_read_d = rfe_pkg::READ_OOR;
                state_d    = S_HOLD;
              end
            end
            rfe_pkg::ACT_QUERY: begin
              if (channel_i < 8'(CHANNELS)) begin
                rd_en   = 1'b1;
                rd_addr = lo_ofs[IW-1:0];
                idx_d   = lo_ofs[IW-1:0];
                state_d = S_QLO;
              end else begin
                res_pulse_d = rfe_pkg::PULSE_BAD_CH;
                state_d     = S_HOLD;
              end
            end
            rfe_pkg::ACT_POLL: begin
              res_ws_d = flag_q;
              flag_d   = 1'b0;
              state_d  = S_HOLD;
            end
            default: begin
            end
          endcase
        end
      end
      S_RDATA: begin
        res_read_d = rd_data;
        state_d    = S_HOLD;
      end
      S_QLO: begin
        off_lo_d = rd_data;
        rd_en    = 1'b1;
        rd_addr  = idx_q + IW'(1);
        state_d  = S_QHI;
      end
      S_QHI: begin
        off_hi_d = rd_data;
        rd_en    = 1'b1;
        rd_addr  = rfe_pkg::PRESCALE_IDX;
        state_d  = S_QPS;
      end
      S_QPS: begin
        pulse_start = 1'b1;
        state_d     = S_ARITH;
      end
      S_ARITH: begin
        if (pulse_done) begin
          res_pulse_d = pulse_res.pulse_us;
          res_ovf_d   = pulse_res.overflow;
          state_d     = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= 8'd0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    off_lo_q    <= off_lo_d;
    off_hi_q    <= off_hi_d;
    res_read_q  <= res_read_d;
    res_pulse_q <= res_pulse_d;
    res_ovf_q   <= res_ovf_d;
    res_ws_q    <= res_ws_d;
    if (out_load) begin
      out_read_q  <= res_read_q;
      out_pulse_q <= res_pulse_q;
      out_ovf_q   <= res_ovf_q;
      out_ws_q    <= res_ws_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_read_q;
  assign pulse_us_o       = out_pulse_q;
  assign pulse_overflow_o = out_ovf_q;
  assign write_seen_o     = out_ws_q;

endmodule

`default_nettype wire

// ----- tb/pwm_register_file_emulator_tb.sv -----
// ----------------------------------------------------------------------------
// pwm_register_file_emulator_tb: self-checking bench for the PWM register file
// A queue of bus transactions feeds a clocked driver. A shadow copy of the
// register file, pointer and write flag predicts every read, pulse width
// query and flag poll, and a clocked monitor compares each returned
// transaction with the oldest prediction under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_register_file_emulator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS     = 2;
  localparam int RANDOM_ITEMS = 1950;
  localparam int END_CYCLES   = 20;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [7:0] channel;
    logic       hold;
  } bus_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pulse_us;
    logic        pulse_overflow;
    logic        write_seen;
  } readback_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i    = '0;
  logic [7:0]  data_byte_i = '0;
  logic [7:0]  channel_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  read_data_o;
  logic [15:0] pulse_us_o;
  logic        pulse_overflow_o;
  logic        write_seen_o;

  bus_item_t bus_items[$];
  readback_t expected_readbacks[$];
  bus_item_t on_bus;
  int        stimulus_total = 0;
  int        sent_count     = 0;
  int        idle_phase     = 0;
  int        mismatches     = 0;

  logic [7:0] shadow_regs [rfe_pkg::REG_BYTES];
  logic [7:0] shadow_ptr  = '0;
  logic       shadow_flag = 1'b0;

  pwm_register_file_emulator #(
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .data_byte_i     (data_byte_i),
    .channel_i       (channel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .pulse_us_o      (pulse_us_o),
    .pulse_overflow_o(pulse_overflow_o),
    .write_seen_o    (write_seen_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void add_item(logic [2:0] action, logic [7:0] data_byte,
                                   logic [7:0] channel, logic hold);
    bus_item_t it;
    it.action    = action;
    it.data_byte = data_byte;
    it.channel   = channel;
    it.hold      = hold;
    bus_items.push_back(it);
  endfunction

  function automatic void shadow_step(bus_item_t it);
    readback_t                 r;
    logic [7:0]                lo_byte;
    logic [rfe_pkg::IDX_W-1:0] lo;
    int unsigned               off_val;
    int unsigned               width;
    r = '0;
    case (it.action)
      rfe_pkg::ACT_SET_PTR: shadow_ptr = it.data_byte;
      rfe_pkg::ACT_WRITE: begin
        if (shadow_ptr < rfe_pkg::REG_BYTES) begin
          shadow_regs[shadow_ptr[rfe_pkg::IDX_W-1:0]] = it.data_byte;
          if (shadow_ptr[1:0] == 2'b01) shadow_flag = 1'b1;
        end else if (shadow_ptr == rfe_pkg::PRESCALE_PTR) begin
          shadow_regs[rfe_pkg::PRESCALE_IDX] = it.data_byte;
          shadow_flag = 1'b1;
        end
        shadow_ptr = shadow_ptr + 8'd1;
      end
      rfe_pkg::ACT_READ: begin
        r.read_data = (shadow_ptr < rfe_pkg::REG_BYTES) ?
                      shadow_regs[shadow_ptr[rfe_pkg::IDX_W-1:0]] : rfe_pkg::READ_OOR;
        expected_readbacks.push_back(r);
      end
      rfe_pkg::ACT_QUERY: begin
        if (it.channel >= CHANNELS) begin
          r.pulse_us = rfe_pkg::PULSE_BAD_CH;
        end else begin
          lo_byte = rfe_pkg::OFF_BASE + {it.channel[5:0], 2'b00};
          lo      = lo_byte[rfe_pkg::IDX_W-1:0];
          off_val = 32'({shadow_regs[lo + 1'b1], shadow_regs[lo]});
          width   = off_val * (32'(shadow_regs[rfe_pkg::PRESCALE_IDX]) + 32'd1) /
                    32'(rfe_pkg::DIVISOR);
          r.pulse_us       = width[15:0];
          r.pulse_overflow = (width > 32'hFFFF);
        end
        expected_readbacks.push_back(r);
      end
      rfe_pkg::ACT_POLL: begin
        r.write_seen = shadow_flag;
        shadow_flag  = 1'b0;
        expected_readbacks.push_back(r);
      end
      default: ;
    endcase
  endfunction

  initial begin
    int         roll;
    int         pick;
    int         burst;
    logic [7:0] ptr;
    logic [2:0] kind;
    shadow_regs = '{default: 8'h00};

    add_item(rfe_pkg::ACT_POLL, 8'h00, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_READ, 8'h00, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_QUERY, 8'h00, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_QUERY, 8'h00, 8'h01, 1'b0);
    add_item(rfe_pkg::ACT_QUERY, 8'h00, 8'h02, 1'b0);
    add_item(rfe_pkg::ACT_QUERY, 8'hFF, 8'hFF, 1'b0);
    add_item(rfe_pkg::ACT_SET_PTR, rfe_pkg::PRESCALE_PTR, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_WRITE, 8'hFF, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_WRITE, 8'hA5, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_READ, 8'h00, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_SET_PTR, rfe_pkg::OFF_BASE, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_WRITE, 8'hFF, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_WRITE, 8'hFF, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_SET_PTR, 8'h0C, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_WRITE, 8'h34, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_WRITE, 8'h12, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_QUERY, 8'h00, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_QUERY, 8'h00, 8'h01, 1'b0);
    add_item(rfe_pkg::ACT_POLL, 8'h00, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_POLL, 8'h00, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_SET_PTR, 8'h10, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_READ, 8'h00, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_SET_PTR, 8'h05, 8'h00, 1'b0);
    add_item(rfe_pkg::ACT_READ, 8'h00, 8'h00, 1'b0);
    add_item(ACT_SPARE_FIRST, 8'hFF, 8'hFF, 1'b0);
    add_item(ACT_SPARE_LAST, 8'h00, 8'h00, 1'b1);

    while (bus_items.size() < 26 + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        pick = $urandom_range(0, 9);
        ptr  = (pick < 7) ? 8'($urandom_range(0, rfe_pkg::REG_BYTES - 1)) :
               (pick < 9) ? rfe_pkg::PRESCALE_PTR : 8'($urandom);
        add_item(rfe_pkg::ACT_SET_PTR, ptr, 8'($urandom), $urandom_range(0, 149) == 0);
        burst = $urandom_range(1, 4);
        kind  = ($urandom_range(0, 2) != 0) ? rfe_pkg::ACT_WRITE : rfe_pkg::ACT_READ;
        repeat (burst) add_item(kind, 8'($urandom), 8'($urandom), 1'b0);
      end else if (roll < 55) begin
        ptr = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, CHANNELS - 1)) : 8'($urandom);
        add_item(rfe_pkg::ACT_QUERY, 8'($urandom), ptr, $urandom_range(0, 149) == 0);
      end else if (roll < 70) begin
        add_item(rfe_pkg::ACT_POLL, 8'($urandom), 8'($urandom), 1'b0);
      end else if (roll < 80) begin
        add_item(rfe_pkg::ACT_READ, 8'($urandom), 8'($urandom), 1'b0);
      end else if (roll < 93) begin
        add_item(rfe_pkg::ACT_WRITE, 8'($urandom), 8'($urandom), 1'b0);
      end else if (roll < 98) begin
        add_item(rfe_pkg::ACT_SET_PTR, 8'($urandom), 8'($urandom), 1'b0);
      end else begin
        add_item(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), 8'($urandom),
                 8'($urandom), 1'b0);
      end
    end
    stimulus_total = bus_items.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (bus_items.size() != 0 || in_valid_i || expected_readbacks.size() != 0)
      @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_readbacks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) shadow_step(on_bus);
      if (!in_valid_i || !in_stall_o) begin
        if (bus_items.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (bus_items[0].hold && expected_readbacks.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if ($urandom_range(0, 99) < (idle_phase == 0 ? 29 : idle_phase == 1 ? 65 : 0))
        begin
          in_valid_i <= 1'b0;
        end else begin
          on_bus       = bus_items.pop_front();
          sent_count   = sent_count + 1;
          idle_phase   = (sent_count * 3) / stimulus_total;
          in_valid_i  <= 1'b1;
          action_i    <= on_bus.action;
          data_byte_i <= on_bus.data_byte;
          channel_i   <= on_bus.channel;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    readback_t got;
    readback_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {read_data_o, pulse_us_o, pulse_overflow_o, write_seen_o};
        if (expected_readbacks.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected transaction: read_data=%h pulse_us=%h ovf=%b seen=%b",
                     got.read_data, got.pulse_us, got.pulse_overflow, got.write_seen);
          mismatches = mismatches + 1;
        end else begin
          want = expected_readbacks.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("mismatch: expected %h %h %b %b actual %h %h %b %b",
                       want.read_data, want.pulse_us, want.pulse_overflow, want.write_seen,
                       got.read_data, got.pulse_us, got.pulse_overflow, got.write_seen);
            mismatches = mismatches + 1;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) <
                      (idle_phase == 0 ? 65 : idle_phase == 1 ? 29 : 0));
    end
  end

endmodule

`default_nettype wire
